// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each macro checks on the rising
// edge of clock and is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define AST_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/skf_pkg.sv =====
`default_nettype none
package skf_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int VAL_W         = 32;
   localparam int CSR_IDX_W     = 1;

   localparam logic [VAL_W-1:0] NOISE_RESET = 32'd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROCESS_NOISE = 1'b0,
      CSR_MEASURE_NOISE = 1'b1
   } csr_index_type;

   // Handshake status of a serial arithmetic unit.
   typedef struct packed {
      logic busy;
      logic done;
   } skf_stat_type;

endpackage
`default_nettype wire

// ===== src/skf_div.sv =====
`default_nettype none
module skf_div
   import skf_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [VAL_W-1:0]     dividend,
   input  wire logic [VAL_W:0]       divisor,
   output skf_stat_type              stat,
   output logic      [FRAC_BITS:0]   quotient
);

   localparam int STEPS = FRAC_BITS + 1;
   localparam int CNT_W = $clog2(STEPS + 1);
   localparam int REM_W = VAL_W + 2;

   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [FRAC_BITS:0] quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [REM_W:0]     trial;
   logic               fits;

   // The dividend never exceeds the divisor, so the first step yields the
   // integer bit and each later step one fraction bit of the quotient.
   always_comb begin
      trial   = {1'b0, rem_ff} - {2'b00, divisor};
      fits    = ~trial[REM_W];
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {2'b00, dividend};
         quo_in  = '0;
         cnt_in  = CNT_W'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = {trial[VAL_W:0], 1'b0};
         end else begin
            rem_in = {rem_ff[VAL_W:0], 1'b0};
         end
         quo_in = {quo_ff[FRAC_BITS-1:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule
`default_nettype wire

// ===== src/skf_mul.sv =====
`default_nettype none
module skf_mul
   import skf_pkg::*;
#(
   parameter int A_W = VAL_W + 1,
   parameter int B_W = FRAC_BITS_DEF + 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [A_W-1:0]        mcand,
   input  wire logic [B_W-1:0]        mplier,
   output skf_stat_type               stat,
   output logic      [A_W+B_W-1:0]    product
);

   localparam int P_W   = A_W + B_W;
   localparam int CNT_W = $clog2(B_W + 1);

   logic [P_W-1:0]   mcand_ff, mcand_in;
   logic [B_W-1:0]   mplier_ff, mplier_in;
   logic [P_W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   // Shift-and-add, one multiplier bit per cycle, least significant first.
   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         mcand_in  = {{B_W{1'b0}}, mcand};
         mplier_in = mplier;
         acc_in    = '0;
         cnt_in    = CNT_W'(B_W);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[P_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[B_W-1:1]};
         cnt_in    = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = acc_ff;

endmodule
`default_nettype wire

// ===== src/scalar_kalman_filter.sv =====
// A transaction passes through the states PRE, DEN, DIV, MUL and FIN; its result
// waits in FIN while the previous result is not yet taken. A new transaction is
// accepted only once the previous one has left FIN, so transactions do not overlap;
// the work is done by the bit-serial divider and the two bit-serial multipliers.
// Reset (synchronous): estimate and error variance clear to zero, both noise
// registers return to 1.0 and no result is pending.
`default_nettype none
`include "assert_macros.svh"
module scalar_kalman_filter
   import skf_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic signed [VAL_W-1:0] req_measurement,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic signed [VAL_W-1:0]     rsp_estimate,
   output logic                        rsp_zero_denominator,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [VAL_W-1:0]       csr_wdata
);

   localparam int G_W    = FRAC_BITS + 1;
   localparam int DIFF_W = VAL_W + 1;
   localparam int P1_W   = DIFF_W + G_W;
   localparam int P2_W   = VAL_W + G_W;
   localparam int STEP_W = VAL_W + 2;
   localparam int XN_W   = VAL_W + 3;

   localparam logic [G_W-1:0]  GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [P1_W-1:0] HALF1    = P1_W'(1) << (FRAC_BITS - 1);
   localparam logic [P2_W-1:0] HALF2    = P2_W'(1) << (FRAC_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRE,
      ST_DEN,
      ST_DIV,
      ST_MUL,
      ST_FIN
   } state_type;

   state_type               state_ff, state_in;
   logic [VAL_W-1:0]        q_ff, q_in;
   logic [VAL_W-1:0]        r_ff, r_in;
   logic signed [VAL_W-1:0] x_ff, x_in;
   logic [VAL_W-1:0]        p_ff, p_in;
   logic signed [VAL_W-1:0] z_ff, z_in;
   logic [DIFF_W-1:0]       diff_ff, diff_in;
   logic [DIFF_W-1:0]       mag_ff, mag_in;
   logic [VAL_W-1:0]        ppre_ff, ppre_in;
   logic [VAL_W:0]          den_ff, den_in;
   logic [G_W-1:0]          gain_ff, gain_in;
   logic [G_W-1:0]          omg_ff, omg_in;
   logic                    flag_ff, flag_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [VAL_W-1:0]        pn_ff, pn_in;
   logic                    div_start_ff, div_start_in;
   logic                    mul_start_ff, mul_start_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] rsp_est_ff, rsp_est_in;
   logic                    rsp_flag_ff, rsp_flag_in;

   logic [VAL_W:0]          var_sum;
   logic [P1_W-1:0]         round1;
   logic [P2_W-1:0]         round2;
   logic [XN_W-1:0]         x_ext;
   logic [XN_W-1:0]         xn;
   logic signed [VAL_W-1:0] x_sat;
   logic                    fin_go;

   skf_stat_type            div_stat;
   skf_stat_type            mul1_stat;
   skf_stat_type            mul2_stat;
   logic [G_W-1:0]          quotient;
   logic [P1_W-1:0]         prod1;
   logic [P2_W-1:0]         prod2;

   skf_div #(
      .FRAC_BITS(FRAC_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start_ff),
      .dividend(ppre_ff),
      .divisor (den_ff),
      .stat    (div_stat),
      .quotient(quotient)
   );

   // Correction term: |z - x| * gain.
   skf_mul #(
      .A_W(DIFF_W),
      .B_W(G_W)
   ) u_mul_innov (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start_ff),
      .mcand  (mag_ff),
      .mplier (gain_ff),
      .stat   (mul1_stat),
      .product(prod1)
   );

   // Updated variance: (1 - gain) * Ppre.
   skf_mul #(
      .A_W(VAL_W),
      .B_W(G_W)
   ) u_mul_var (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start_ff),
      .mcand  (ppre_ff),
      .mplier (omg_ff),
      .stat   (mul2_stat),
      .product(prod2)
   );

   always_comb begin
      var_sum = {1'b0, p_ff} + {1'b0, q_ff};
      round1  = prod1 + HALF1;
      round2  = prod2 + HALF2;
      x_ext   = {{(XN_W-VAL_W){x_ff[VAL_W-1]}}, x_ff};
      if (diff_ff[DIFF_W-1]) begin
         xn = x_ext - {{(XN_W-STEP_W){1'b0}}, step_ff};
      end else begin
         xn = x_ext + {{(XN_W-STEP_W){1'b0}}, step_ff};
      end
      // Clamp to the signed 32-bit range when the upper bits disagree.
      if (xn[XN_W-1:VAL_W-1] == '0 || xn[XN_W-1:VAL_W-1] == '1) begin
         x_sat = xn[VAL_W-1:0];
      end else if (xn[XN_W-1]) begin
         x_sat = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         x_sat = {1'b0, {(VAL_W-1){1'b1}}};
      end
      fin_go = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in     = state_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      x_in         = x_ff;
      p_in         = p_ff;
      z_in         = z_ff;
      diff_in      = diff_ff;
      mag_in       = mag_ff;
      ppre_in      = ppre_ff;
      den_in       = den_ff;
      gain_in      = gain_ff;
      omg_in       = omg_ff;
      flag_in      = flag_ff;
      step_in      = step_ff;
      pn_in        = pn_ff;
      div_start_in = 1'b0;
      mul_start_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_est_in   = rsp_est_ff;
      rsp_flag_in  = rsp_flag_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_PROCESS_NOISE: q_in = csr_wdata;
            CSR_MEASURE_NOISE: r_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               z_in     = req_measurement;
               state_in = ST_PRE;
            end
         end
         ST_PRE: begin
            ppre_in  = var_sum[VAL_W] ? '1 : var_sum[VAL_W-1:0];
            diff_in  = {z_ff[VAL_W-1], z_ff} - {x_ff[VAL_W-1], x_ff};
            state_in = ST_DEN;
         end
         ST_DEN: begin
            den_in       = {1'b0, ppre_ff} + {1'b0, r_ff};
            mag_in       = diff_ff[DIFF_W-1] ? -diff_ff : diff_ff;
            div_start_in = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               flag_in      = (den_ff == '0);
               gain_in      = (den_ff == '0) ? '0 : quotient;
               omg_in       = (den_ff == '0) ? GAIN_ONE : GAIN_ONE - quotient;
               mul_start_in = 1'b1;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul1_stat.done) begin
               step_in  = round1[FRAC_BITS+STEP_W-1:FRAC_BITS];
               pn_in    = round2[FRAC_BITS+VAL_W-1:FRAC_BITS];
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (fin_go) begin
               x_in         = x_sat;
               p_in         = pn_ff;
               rsp_valid_in = 1'b1;
               rsp_est_in   = x_sat;
               rsp_flag_in  = flag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         q_ff         <= NOISE_RESET;
         r_ff         <= NOISE_RESET;
         x_ff         <= '0;
         p_ff         <= '0;
         div_start_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         q_ff         <= q_in;
         r_ff         <= r_in;
         x_ff         <= x_in;
         p_ff         <= p_in;
         div_start_ff <= div_start_in;
         mul_start_ff <= mul_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      z_ff        <= z_in;
      diff_ff     <= diff_in;
      mag_ff      <= mag_in;
      ppre_ff     <= ppre_in;
      den_ff      <= den_in;
      gain_ff     <= gain_in;
      omg_ff      <= omg_in;
      flag_ff     <= flag_in;
      step_ff     <= step_in;
      pn_ff       <= pn_in;
      rsp_est_ff  <= rsp_est_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_estimate         = rsp_est_ff;
   assign rsp_zero_denominator = rsp_flag_ff;

   `AST_NEXT(a_accept_starts, req_valid && req_ready, state_ff == ST_PRE)
   `AST_IMPLY(a_div_done_in_div, div_stat.busy || div_stat.done, state_ff == ST_DIV)
   `AST_IMPLY(a_mul_busy_in_mul, mul1_stat.busy || mul2_stat.busy, state_ff == ST_MUL)
   `AST_IMPLY(a_mul_in_step, mul1_stat.done, mul2_stat.done && state_ff == ST_MUL)
   `AST_IMPLY(a_var_shrinks, fin_go, pn_ff <= ppre_ff)
   `AST_IMPLY(a_zero_den_holds, fin_go && flag_ff, x_sat == x_ff)

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

import skf_pkg::*;

// Tracks the filter state on the testbench side and checks every estimate in order.
class estimate_board;
   typedef struct {
      logic signed [31:0] estimate;
      logic               zero_den;
   } estimate_item;

   logic [31:0]        q_noise;
   logic [31:0]        r_noise;
   logic [31:0]        var_p;
   logic signed [31:0] est;
   estimate_item       expected_q[$];
   int                 errors;
   int                 checked;
   int                 zero_den_seen;

   function new();
      q_noise       = NOISE_RESET;
      r_noise       = NOISE_RESET;
      var_p         = '0;
      est           = '0;
      errors        = 0;
      checked       = 0;
      zero_den_seen = 0;
   endfunction

   function void write_noise(csr_index_type idx, logic [31:0] data);
      case (idx)
         CSR_PROCESS_NOISE: q_noise = data;
         CSR_MEASURE_NOISE: r_noise = data;
         default: ;
      endcase
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   // One filter step: predict, compute the gain, update estimate and variance.
   function void note_measurement(logic signed [31:0] z);
      logic [63:0]  one;
      logic [63:0]  half;
      logic [63:0]  ppre;
      logic [63:0]  den;
      logic [63:0]  gain;
      logic [63:0]  mag;
      logic [63:0]  step;
      logic [63:0]  pn;
      longint       diff;
      longint       xn;
      estimate_item item;
      one  = 64'd1 << FRAC_BITS_DEF;
      half = 64'd1 << (FRAC_BITS_DEF - 1);
      ppre = {32'd0, var_p} + {32'd0, q_noise};
      if (ppre > 64'hFFFF_FFFF) ppre = 64'hFFFF_FFFF;
      den  = ppre + {32'd0, r_noise};
      gain = '0;
      item.zero_den = 1'b0;
      if (den == 64'd0) begin
         item.zero_den = 1'b1;
      end else begin
         gain = (ppre << FRAC_BITS_DEF) / den;
      end
      diff = longint'(z) - longint'(est);
      mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
      step = (mag * gain + half) >> FRAC_BITS_DEF;
      xn   = (diff < 0) ? longint'(est) - longint'(step) : longint'(est) + longint'(step);
      if (xn > 64'sd2147483647) xn = 64'sd2147483647;
      if (xn < -64'sd2147483648) xn = -64'sd2147483648;
      pn = ((one - gain) * ppre + half) >> FRAC_BITS_DEF;
      if (pn > 64'hFFFF_FFFF) pn = 64'hFFFF_FFFF;
      est   = xn[31:0];
      var_p = pn[31:0];
      item.estimate = est;
      expected_q.push_back(item);
   endfunction

   function void check_estimate(logic signed [31:0] estimate, logic zero_den);
      estimate_item item;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result transaction: estimate %h zero_denominator %b",
                  $time, estimate, zero_den);
         errors++;
         return;
      end
      item = expected_q.pop_front();
      checked++;
      if (zero_den) zero_den_seen++;
      if (estimate !== item.estimate) begin
         $display("%0t: estimate mismatch: expected %h actual %h",
                  $time, item.estimate, estimate);
         errors++;
      end
      if (zero_den !== item.zero_den) begin
         $display("%0t: zero_denominator mismatch: expected %b actual %b",
                  $time, item.zero_den, zero_den);
         errors++;
      end
   endfunction
endclass

module tb_top;
   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 60;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_measurement;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_estimate;
   logic               rsp_zero_denominator;
   logic               csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]        csr_wdata;

   estimate_board sb = new();
   int  sent;
   int  settings_used;
   int  send_idle_pct;
   int  rsp_idle_pct;
   int  quiet;

   scalar_kalman_filter dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_measurement      (req_measurement),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_estimate         (rsp_estimate),
      .rsp_zero_denominator (rsp_zero_denominator),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Called just after a falling edge; returns just after the falling edge that follows acceptance.
   task automatic send_measurement(input logic [31:0] z);
      req_valid       = 1'b1;
      req_measurement = z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_measurement(z);
      sent++;
      @(negedge clock);
   endtask

   task automatic sender_gap();
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // Both registers are written only once the filter has nothing in flight.
   task automatic set_noise(input logic [31:0] q, input logic [31:0] r);
      wait_drained();
      csr_we    = 1'b1;
      csr_index = CSR_PROCESS_NOISE;
      csr_wdata = q;
      @(negedge clock);
      csr_index = CSR_MEASURE_NOISE;
      csr_wdata = r;
      @(negedge clock);
      csr_we = 1'b0;
      sb.write_noise(CSR_PROCESS_NOISE, q);
      sb.write_noise(CSR_MEASURE_NOISE, r);
      settings_used++;
   endtask

   task automatic run_phase(input logic [31:0] q, input logic [31:0] r, input int count,
                            input int idle_pct, input bit hold_mid);
      logic [31:0] z;
      int          pick;
      set_noise(q, r);
      send_idle_pct = idle_pct;
      rsp_idle_pct  = idle_pct;
      for (int i = 0; i < count; i++) begin
         if (hold_mid && i == count / 2) wait_drained();
         sender_gap();
         pick = $urandom_range(0, 9);
         // Half of the samples lie near the current estimate, as a real sensor gives.
         if (pick <= 4) begin
            z = sb.est + ($urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000);
         end else if (pick <= 7) begin
            z = $urandom;
         end else if (pick == 8) begin
            z = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         end else begin
            z = $urandom_range(0, 15) - 8;
         end
         send_measurement(z);
      end
   endtask

   // Result side: ready drops in random bursts.
   initial begin
      int stall;
      stall     = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            stall--;
         end else if (rsp_idle_pct > 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_ready = 1'b0;
            stall = $urandom_range(0, 7);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_estimate(rsp_estimate, rsp_zero_denominator);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_measurement = '0;
      csr_we          = 1'b0;
      csr_index       = CSR_PROCESS_NOISE;
      csr_wdata       = '0;
      sent            = 0;
      settings_used   = 0;
      send_idle_pct   = 20;
      rsp_idle_pct    = 20;
      quiet           = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset noise values, extreme samples with the largest jumps.
      send_measurement(32'h0000_0000);
      send_measurement(32'h7FFF_FFFF);
      send_measurement(32'h8000_0000);
      sender_gap();
      send_measurement(32'h7FFF_FFFF);
      send_measurement(32'hFFFF_FFFF);
      send_measurement(32'h0000_0001);
      send_measurement(32'h0001_0000);
      // No noise at all: the first step takes gain 1.0 and empties the variance,
      // so the following steps hit a zero denominator.
      set_noise(32'h0000_0000, 32'h0000_0000);
      send_measurement(32'h8000_0000);
      send_measurement(32'h7FFF_FFFF);
      send_measurement(32'h1234_5678);
      // Huge noise on both sides drives the predicted variance into saturation.
      set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_measurement(32'h8000_0000);
      send_measurement(32'h7FFF_FFFF);
      send_measurement(32'h0000_0000);
      send_measurement(32'h8000_0000);
      set_noise(32'h0000_0000, 32'hFFFF_FFFF);
      send_measurement(32'h7FFF_FFFF);
      send_measurement(32'h8000_0000);
      send_measurement(32'h5555_5555);
      send_measurement(32'hAAAA_AAAA);
      set_noise(32'hFFFF_FFFF, 32'h0000_0000);
      send_measurement(32'h8000_0000);
      send_measurement(32'h7FFF_FFFF);
      send_measurement(32'h0000_0000);
      set_noise(32'h0000_0001, 32'h0000_0000);
      send_measurement(32'hFFFF_0000);
      send_measurement(32'h0000_FFFF);

      run_phase(NOISE_RESET, NOISE_RESET, 150, 25, 1'b1);
      run_phase(32'h0000_0000, $urandom_range(1, 32'h0010_0000), 150, 15, 1'b0);
      run_phase($urandom, 32'h0000_0000, 150, 35, 1'b0);
      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 150, 10, 1'b0);
      run_phase($urandom_range(0, 32'h0000_4000), $urandom_range(0, 32'h0004_0000),
                150, 30, 1'b1);
      run_phase($urandom, $urandom, 150, 20, 1'b0);
      run_phase(32'h0000_0000, 32'h0000_0000, 150, 25, 1'b0);
      run_phase($urandom_range(0, 32'h0100_0000), $urandom, 150, 15, 1'b0);
      // Closing stretch runs at full rate on both sides.
      run_phase($urandom_range(0, 32'h0002_0000), $urandom_range(0, 32'h0002_0000),
                150, 0, 1'b0);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d measurements over %0d noise settings; %0d estimates checked.",
               sent, settings_used, sb.checked);
      $display("Zero-denominator results seen: %0d; errors: %0d.",
               sb.zero_den_seen, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
